// ===== rtl/btc_pkg.sv =====
// ----------------------------------------------------------------------------
// btc_pkg
// shared types and constants of the 4x4 block truncation coding core
// ----------------------------------------------------------------------------
package btc_pkg;

  localparam int SIDE      = 4;
  localparam int PIX_W     = 8;
  localparam int ROW_W     = $clog2(SIDE);
  localparam int NPIX      = SIDE * SIDE;
  localparam int SUM_W     = PIX_W + $clog2(NPIX);
  localparam int CNT_W     = $clog2(NPIX) + 1;
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int QCNT_W    = $clog2(QDEPTH + 1);
  localparam int STEP_W    = $clog2(PIX_W);

  typedef logic [PIX_W-1:0] pixel_t;
  typedef pixel_t [SIDE-1:0] row_t;
  typedef row_t [SIDE-1:0] block_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_CLASS,
    ST_DIV_START,
    ST_DIV,
    ST_EMIT
  } back_state_t;

endpackage

// ===== rtl/block_truncation_coding_4x4_core.sv =====
// ----------------------------------------------------------------------------
// block_truncation_coding_4x4_core
// 4x4 absolute moment block truncation coding, row in and row out
// ----------------------------------------------------------------------------
// output: each block comes out as four result rows, one result row per cycle,
//   last_row on the fourth
// throughput: one row per cycle until the two-block queue fills; the back end
//   works on one block at a time (four-row sum, four-row grouping, 8-step divide)
// reset: synchronous, clears row count, queue and sequencer; results cannot stall
module block_truncation_coding_4x4_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] pixel_0,
  input  logic [7:0] pixel_1,
  input  logic [7:0] pixel_2,
  input  logic [7:0] pixel_3,
  output logic       done,
  output logic [7:0] level_0,
  output logic [7:0] level_1,
  output logic [7:0] level_2,
  output logic [7:0] level_3,
  output logic       last_row
);

  btc_pkg::row_t      row_in;
  btc_pkg::row_t      levels;
  btc_pkg::q_status_t q_status;
  btc_pkg::block_t    push_data;
  btc_pkg::block_t    head;
  logic               push;
  logic               pop;

  assign row_in  = {pixel_3, pixel_2, pixel_1, pixel_0};
  assign level_0 = levels[0];
  assign level_1 = levels[1];
  assign level_2 = levels[2];
  assign level_3 = levels[3];

  btc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .row_in    (row_in),
    .q_status  (q_status),
    .busy      (busy),
    .push      (push),
    .push_data (push_data)
  );

  btc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  btc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .q_status (q_status),
    .pop      (pop),
    .done     (done),
    .levels   (levels),
    .last_row (last_row)
  );

endmodule

// ===== rtl/btc_front.sv =====
// ----------------------------------------------------------------------------
// btc_front
// collects incoming rows and pushes a complete block into the queue
// ----------------------------------------------------------------------------
module btc_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  btc_pkg::row_t      row_in,
  input  btc_pkg::q_status_t q_status,
  output logic               busy,
  output logic               push,
  output btc_pkg::block_t    push_data
);

  logic [btc_pkg::ROW_W-1:0] rows_loaded;
  btc_pkg::block_t           stage;
  logic                      accept;

  assign busy   = q_status.full;
  assign accept = start && !busy;
  assign push   = accept && (rows_loaded == btc_pkg::ROW_W'(btc_pkg::SIDE - 1));

  always_comb begin
    push_data = stage;
    push_data[btc_pkg::SIDE-1] = row_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_loaded <= '0;
    end else if (accept) begin
      rows_loaded <= rows_loaded + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage[rows_loaded] <= row_in;
    end
  end

endmodule

// ===== rtl/btc_queue.sv =====
// ----------------------------------------------------------------------------
// btc_queue
// two-entry block queue between front and back
// ----------------------------------------------------------------------------
module btc_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  btc_pkg::block_t    push_data,
  input  logic               pop,
  output btc_pkg::block_t    head,
  output btc_pkg::q_status_t status
);

  btc_pkg::block_t            entries [btc_pkg::QDEPTH];
  logic [btc_pkg::QPTR_W-1:0] wr_ptr;
  logic [btc_pkg::QPTR_W-1:0] rd_ptr;
  logic [btc_pkg::QCNT_W-1:0] count;

  assign head         = entries[rd_ptr];
  assign status.full  = (count == btc_pkg::QCNT_W'(btc_pkg::QDEPTH));
  assign status.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !status.full || pop)
    else $error("block pushed into a full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !status.empty)
    else $error("block popped from an empty queue");

endmodule

// ===== rtl/btc_div.sv =====
// ----------------------------------------------------------------------------
// btc_div
// restoring divider, one quotient bit per cycle, group sum by group count
// ----------------------------------------------------------------------------
module btc_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [btc_pkg::SUM_W-1:0]  dividend,
  input  logic [btc_pkg::CNT_W-1:0]  divisor,
  output logic                       done,
  output btc_pkg::pixel_t            quotient
);

  logic                        run;
  logic [btc_pkg::STEP_W-1:0]  step;
  logic [btc_pkg::CNT_W-1:0]   rem;
  btc_pkg::pixel_t             dvd;
  logic [btc_pkg::CNT_W:0]     trial;
  logic                        fits;

  // quotient never exceeds the largest pixel, so the upper bits start below divisor
  assign trial = {rem, dvd[btc_pkg::PIX_W-1]};
  assign fits  = (trial >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run  <= 1'b1;
        step <= '0;
      end else if (run) begin
        step <= step + 1'b1;
        if (step == btc_pkg::STEP_W'(btc_pkg::PIX_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= btc_pkg::CNT_W'(dividend[btc_pkg::SUM_W-1:btc_pkg::PIX_W]);
      dvd      <= dividend[btc_pkg::PIX_W-1:0];
      quotient <= '0;
    end else if (run) begin
      rem      <= fits ? btc_pkg::CNT_W'(trial - {1'b0, divisor})
                       : btc_pkg::CNT_W'(trial);
      dvd      <= {dvd[btc_pkg::PIX_W-2:0], 1'b0};
      quotient <= {quotient[btc_pkg::PIX_W-2:0], fits};
    end
  end

endmodule

// ===== rtl/btc_back.sv =====
// ----------------------------------------------------------------------------
// btc_back
// block mean, high/low grouping, group levels and row reconstruction
// ----------------------------------------------------------------------------
module btc_back (
  input  logic               clk,
  input  logic               rst,
  input  btc_pkg::block_t    head,
  input  btc_pkg::q_status_t q_status,
  output logic               pop,
  output logic               done,
  output btc_pkg::row_t      levels,
  output logic               last_row
);

  btc_pkg::back_state_t        state, state_next;
  btc_pkg::block_t             blk;
  logic [btc_pkg::ROW_W-1:0]   row;
  logic [btc_pkg::SUM_W-1:0]   total;
  logic [btc_pkg::SUM_W-1:0]   hi_sum, lo_sum;
  logic [btc_pkg::CNT_W-1:0]   hi_cnt, lo_cnt;
  logic [btc_pkg::SIDE-1:0]    hi_mask [btc_pkg::SIDE];
  btc_pkg::pixel_t             mean;
  btc_pkg::row_t               cur_row;
  logic [btc_pkg::SIDE-1:0]    row_hi;
  logic [btc_pkg::SUM_W-1:0]   row_sum, row_hi_sum, row_lo_sum;
  logic [btc_pkg::CNT_W-1:0]   row_hi_cnt;
  logic                        last;
  logic                        div_start;
  logic                        hi_done, lo_done;
  btc_pkg::pixel_t             hi_q, lo_q;
  btc_pkg::pixel_t             hi_lvl, lo_lvl;

  assign mean    = total[btc_pkg::SUM_W-1:btc_pkg::SUM_W-btc_pkg::PIX_W];
  assign cur_row = blk[row];
  assign last    = (row == btc_pkg::ROW_W'(btc_pkg::SIDE - 1));
  assign hi_lvl  = (hi_cnt == '0) ? '0 : hi_q;
  assign lo_lvl  = (lo_cnt == '0) ? '0 : lo_q;

  always_comb begin
    row_sum    = '0;
    row_hi_sum = '0;
    row_lo_sum = '0;
    row_hi_cnt = '0;
    for (int c = 0; c < btc_pkg::SIDE; c++) begin
      row_hi[c] = (cur_row[c] >= mean);
      row_sum   = row_sum + btc_pkg::SUM_W'(cur_row[c]);
      if (row_hi[c]) begin
        row_hi_sum = row_hi_sum + btc_pkg::SUM_W'(cur_row[c]);
        row_hi_cnt = row_hi_cnt + 1'b1;
      end else begin
        row_lo_sum = row_lo_sum + btc_pkg::SUM_W'(cur_row[c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= btc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    div_start  = 1'b0;
    unique case (state)
      btc_pkg::ST_IDLE: begin
        if (!q_status.empty) begin
          pop        = 1'b1;
          state_next = btc_pkg::ST_SUM;
        end
      end
      btc_pkg::ST_SUM: begin
        if (last) state_next = btc_pkg::ST_CLASS;
      end
      btc_pkg::ST_CLASS: begin
        if (last) state_next = btc_pkg::ST_DIV_START;
      end
      btc_pkg::ST_DIV_START: begin
        div_start  = 1'b1;
        state_next = btc_pkg::ST_DIV;
      end
      btc_pkg::ST_DIV: begin
        if (hi_done) state_next = btc_pkg::ST_EMIT;
      end
      btc_pkg::ST_EMIT: begin
        if (last) state_next = btc_pkg::ST_IDLE;
      end
      default: state_next = btc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row  <= '0;
      done <= 1'b0;
    end else begin
      done <= (state == btc_pkg::ST_EMIT);
      if (state == btc_pkg::ST_IDLE || state == btc_pkg::ST_DIV_START) begin
        row <= '0;
      end else if (state == btc_pkg::ST_SUM || state == btc_pkg::ST_CLASS ||
                   state == btc_pkg::ST_EMIT) begin
        row <= row + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      btc_pkg::ST_IDLE: begin
        blk    <= head;
        total  <= '0;
        hi_sum <= '0;
        lo_sum <= '0;
        hi_cnt <= '0;
        lo_cnt <= '0;
      end
      btc_pkg::ST_SUM: begin
        total <= total + row_sum;
      end
      btc_pkg::ST_CLASS: begin
        hi_mask[row] <= row_hi;
        hi_sum       <= hi_sum + row_hi_sum;
        lo_sum       <= lo_sum + row_lo_sum;
        hi_cnt       <= hi_cnt + row_hi_cnt;
        lo_cnt       <= lo_cnt + (btc_pkg::CNT_W'(btc_pkg::SIDE) - row_hi_cnt);
      end
      btc_pkg::ST_EMIT: begin
        for (int c = 0; c < btc_pkg::SIDE; c++) begin
          levels[c] <= hi_mask[row][c] ? hi_lvl : lo_lvl;
        end
        last_row <= last;
      end
      default: begin
      end
    endcase
  end

  btc_div u_div_hi (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (hi_sum),
    .divisor  (hi_cnt),
    .done     (hi_done),
    .quotient (hi_q)
  );

  btc_div u_div_lo (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (lo_sum),
    .divisor  (lo_cnt),
    .done     (lo_done),
    .quotient (lo_q)
  );

  a_hi_group: assert property (@(posedge clk) disable iff (rst)
    state == btc_pkg::ST_DIV |-> hi_cnt != '0 && hi_cnt + lo_cnt == btc_pkg::CNT_W'(btc_pkg::NPIX))
    else $error("group counts do not cover the block");

  a_div_lockstep: assert property (@(posedge clk) disable iff (rst)
    hi_done |-> lo_done && state == btc_pkg::ST_DIV)
    else $error("dividers out of step");

  a_gap_after_block: assert property (@(posedge clk) disable iff (rst)
    done && last_row |=> !done)
    else $error("row strobe right after the last row of a block");

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// regression for the 4x4 block truncation coding core: rows of a block go in
// through the start/busy handshake, a scoreboard predicts the four rebuilt
// rows of every block and checks each strobed result row against them
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import btc_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    pixel_t lvl [SIDE];
    logic   last;
  } recon_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic       busy;
  logic [7:0] pixel_0 = '0;
  logic [7:0] pixel_1 = '0;
  logic [7:0] pixel_2 = '0;
  logic [7:0] pixel_3 = '0;
  logic       done;
  logic [7:0] level_0;
  logic [7:0] level_1;
  logic [7:0] level_2;
  logic [7:0] level_3;
  logic       last_row;

  recon_row_t pending_rows [$];
  pixel_t     tile_pix [NPIX];
  int         rows_in = 0;
  int         errors = 0;
  int         cycles = 0;
  bit         calm = 1'b0;

  block_truncation_coding_4x4_core u_top (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .pixel_0  (pixel_0),
    .pixel_1  (pixel_1),
    .pixel_2  (pixel_2),
    .pixel_3  (pixel_3),
    .done     (done),
    .level_0  (level_0),
    .level_1  (level_1),
    .level_2  (level_2),
    .level_3  (level_3),
    .last_row (last_row)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t timeout with %0d rows outstanding", $time, pending_rows.size());
      $display("block_truncation_coding_4x4_core regression: fail");
      $finish;
    end
  end

  // store a row, and on the fourth row predict the rebuilt block
  task automatic absorb_row(input row_t r);
    int         total;
    int         hi_sum;
    int         lo_sum;
    int         hi_cnt;
    int         lo_cnt;
    int         mean;
    pixel_t     hi_lvl;
    pixel_t     lo_lvl;
    recon_row_t rr;
    for (int c = 0; c < SIDE; c++) tile_pix[rows_in*SIDE + c] = r[c];
    if (rows_in < SIDE - 1) begin
      rows_in++;
      return;
    end
    rows_in = 0;
    total = 0;
    for (int i = 0; i < NPIX; i++) total += tile_pix[i];
    mean = total / NPIX;
    hi_sum = 0;
    lo_sum = 0;
    hi_cnt = 0;
    lo_cnt = 0;
    for (int i = 0; i < NPIX; i++) begin
      if (tile_pix[i] >= mean) begin
        hi_sum += tile_pix[i];
        hi_cnt++;
      end else begin
        lo_sum += tile_pix[i];
        lo_cnt++;
      end
    end
    hi_lvl = (hi_cnt != 0) ? pixel_t'(hi_sum / hi_cnt) : '0;
    lo_lvl = (lo_cnt != 0) ? pixel_t'(lo_sum / lo_cnt) : '0;
    for (int rw = 0; rw < SIDE; rw++) begin
      for (int c = 0; c < SIDE; c++)
        rr.lvl[c] = (tile_pix[rw*SIDE + c] >= mean) ? hi_lvl : lo_lvl;
      rr.last = (rw == SIDE - 1);
      pending_rows.push_back(rr);
    end
  endtask

  task automatic send_row(input row_t r);
    int gap;
    if (!calm && $urandom_range(99) < 23) begin
      gap = ($urandom_range(9) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 4);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    pixel_0 <= r[0];
    pixel_1 <= r[1];
    pixel_2 <= r[2];
    pixel_3 <= r[3];
    do @(posedge clk); while (busy !== 1'b0);
    absorb_row(r);
  endtask

  task automatic send_block(input pixel_t px [NPIX]);
    row_t r;
    for (int rw = 0; rw < SIDE; rw++) begin
      for (int c = 0; c < SIDE; c++) r[c] = px[rw*SIDE + c];
      send_row(r);
    end
  endtask

  task automatic test_directed_blocks();
    pixel_t px [NPIX];
    // flat black, low group empty
    foreach (px[i]) px[i] = 8'h00;
    send_block(px);
    // flat white
    foreach (px[i]) px[i] = 8'hff;
    send_block(px);
    // one bright pixel on black
    foreach (px[i]) px[i] = 8'h00;
    px[NPIX-1] = 8'hff;
    send_block(px);
    // one dark pixel on white
    foreach (px[i]) px[i] = 8'hff;
    px[0] = 8'h00;
    send_block(px);
    // ramp
    foreach (px[i]) px[i] = pixel_t'(i * 17);
    send_block(px);
    // checkerboard
    foreach (px[i]) px[i] = (i[0] ^ i[2]) ? 8'haa : 8'h55;
    send_block(px);
  endtask

  task automatic test_random_blocks(input int n_blocks);
    pixel_t px [NPIX];
    int     mode;
    int     base;
    int     spread;
    pixel_t pa;
    pixel_t pb;
    for (int b = 0; b < n_blocks; b++) begin
      mode   = $urandom_range(5);
      base   = $urandom_range(255);
      spread = $urandom_range(1, 6);
      pa     = pixel_t'($urandom_range(255));
      pb     = pixel_t'($urandom_range(255));
      foreach (px[i]) begin
        case (mode)
          0, 1: px[i] = pixel_t'($urandom_range(255));
          2: begin
            px[i] = pixel_t'(base + $urandom_range(2*spread) - spread);
          end
          3: px[i] = $urandom_range(1) ? pa : pb;
          4: px[i] = $urandom_range(1) ? 8'hff : 8'h00;
          default: px[i] = ($urandom_range(15) == 0) ? pb : pa;
        endcase
      end
      send_block(px);
    end
  endtask

  task automatic test_back_to_back(input int n_blocks);
    calm = 1'b1;
    test_random_blocks(n_blocks);
    calm = 1'b0;
  endtask

  always @(posedge clk) begin
    recon_row_t want;
    pixel_t     got [SIDE];
    if (!rst && done === 1'b1) begin
      got = '{level_0, level_1, level_2, level_3};
      if (pending_rows.size() == 0) begin
        $display("%0t unexpected result row: expected none, actual %h %h %h %h last %b",
                 $time, level_0, level_1, level_2, level_3, last_row);
        errors++;
      end else begin
        want = pending_rows.pop_front();
        for (int c = 0; c < SIDE; c++) begin
          if (got[c] !== want.lvl[c]) begin
            $display("%0t level_%0d mismatch: expected %h, actual %h",
                     $time, c, want.lvl[c], got[c]);
            errors++;
          end
        end
        if (last_row !== want.last) begin
          $display("%0t last_row mismatch: expected %b, actual %b",
                   $time, want.last, last_row);
          errors++;
        end
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_blocks();
    test_random_blocks(74);
    test_back_to_back(25);
    start <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("block_truncation_coding_4x4_core regression: pass");
    end else begin
      $display("block_truncation_coding_4x4_core regression: fail");
    end
    $finish;
  end

endmodule
